>>> src/ppc_pkg.sv
package ppc_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = 25;
    localparam int MUL_W      = 26;
    localparam int PROD_W     = 52;
    localparam int SQ_W       = 50;
    localparam int ROOT_W     = 25;
    localparam int LOOK_W     = 23;
    localparam int HEAD_W     = 16;
    localparam int CURV_W     = 32;
    localparam int ANG_W      = 34;
    localparam int TRIG_W     = 16;
    localparam int CURV_SHIFT = 11;
    localparam int CORDIC_N   = 16;

    localparam logic [LOOK_W-1:0] LOOK_RESET = 23'd26;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sd652032874;

    localparam logic [1:0] CMD_POINT = 2'd0;
    localparam logic [1:0] CMD_POSE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [7:0]                point_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [HEAD_W-1:0]  heading;
        logic                      last_point;
    } t_req;

    typedef struct packed {
        logic signed [CURV_W-1:0] curvature;
        logic                     velocity_on;
        logic                     target_found;
    } t_rsp;

    typedef enum logic [5:0] {
        ST_IDLE, ST_RD, ST_LD,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
        ST_SQN, ST_DVD, ST_R0, ST_R1, ST_R2, ST_WHS,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4,
        ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_C8, ST_C9, ST_C10,
        ST_NEXT, ST_OUT
    } t_state;

    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [3:0] i);
        case (i)
            4'd0:    return 34'sd843314857;
            4'd1:    return 34'sd497837830;
            4'd2:    return 34'sd263043837;
            4'd3:    return 34'sd133525159;
            4'd4:    return 34'sd67021687;
            4'd5:    return 34'sd33543516;
            4'd6:    return 34'sd16775851;
            4'd7:    return 34'sd8388437;
            4'd8:    return 34'sd4194282;
            4'd9:    return 34'sd2097149;
            4'd10:   return 34'sd1048576;
            4'd11:   return 34'sd524288;
            4'd12:   return 34'sd262144;
            4'd13:   return 34'sd131072;
            4'd14:   return 34'sd65536;
            default: return 34'sd32768;
        endcase
    endfunction

    function automatic logic [PROD_W-1:0] mag_of(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] t;
        t = v;
        return v[PROD_W-1] ? (~t + 1'b1) : t;
    endfunction

endpackage

>>> src/pure_pursuit_curvature_core.sv
// channel   signals                         direction
// request   i_req_valid, o_req_stall, i_req  in
// response  o_rsp_valid, i_rsp_stall, o_rsp  out
// config    i_cfg_we, i_cfg_data             in
//
// point and pose requests are taken while idle; a tick walks the path segment by segment,
// using the divider and square root on each, and on the first hit computes the hit point
// and curvature; a path holds up to 256 points
// synchronous active-low reset clears control state; path memory is undefined until written
// o_req_stall is high while a tick runs; a finished tick waits for the response register
module pure_pursuit_curvature_core import ppc_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  t_req              i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output t_rsp              o_rsp,
    input  logic              i_cfg_we,
    input  logic [LOOK_W-1:0] i_cfg_data
);

    localparam int SLOTS = 2 ** $bits(i_req.point_index);
    localparam int DEPTH = MAX_POINTS < SLOTS ? MAX_POINTS : SLOTS;
    localparam int AW    = $clog2(DEPTH);

    t_state r_state, n_state;

    logic [8:0]                r_path_len;
    logic                      r_path_ok;
    logic                      r_pose_ok;
    logic signed [COORD_W-1:0] r_pose_x;
    logic signed [COORD_W-1:0] r_pose_y;
    logic signed [HEAD_W-1:0]  r_pose_hd;
    logic [LOOK_W-1:0]         r_look;
    logic                      r_rsp_valid;
    t_rsp                      r_rsp;
    logic                      r_first;

    logic [8:0]                r_idx;
    logic signed [COORD_W-1:0] r_sx, r_sy, r_x1, r_y1, r_hx, r_hy;
    logic signed [DIFF_W-1:0]  r_ex, r_ey, r_fx, r_fy, r_dx, r_dy;
    logic signed [PROD_W-1:0]  r_prod, r_t0, r_t1, r_a, r_cross, r_dot;
    logic [ROOT_W-1:0]         r_n, r_u;
    logic [LOOK_W-1:0]         r_d;
    logic [PROD_W-1:0]         r_r2;
    logic                      r_pos;
    t_rsp                      r_res;

    logic                      acc;
    logic                      idx_ok;
    logic                      ram_we;
    logic [2*COORD_W-1:0]      ram_rdata;
    logic signed [COORD_W-1:0] rd_x, rd_y;

    logic signed [MUL_W-1:0]   m_a, m_b;
    logic signed [PROD_W-1:0]  m_p;

    logic                      div_start, div_busy;
    logic [PROD_W-1:0]         div_a, div_b, div_q;
    logic                      sq_start, sq_busy;
    logic [SQ_W-1:0]           sq_rad;
    logic [ROOT_W-1:0]         sq_root;
    logic                      cor_start, cor_busy;
    logic signed [TRIG_W-1:0]  cor_cos, cor_sin;

    logic signed [PROD_W-1:0]  s_val, u_lo, u_hi, n_ext, h_ext;
    logic                      lo_ok, hi_ok;
    logic signed [MUL_W-1:0]   h_off, h_sum;
    logic signed [COORD_W-1:0] h_base;
    logic                      h_sign;
    logic signed [PROD_W-1:0]  ss_val;
    logic [32:0]               neg_q;
    logic [CURV_W-1:0]         curv;

    assign acc    = i_req_valid && (r_state == ST_IDLE);
    assign idx_ok = int'({24'd0, i_req.point_index}) < MAX_POINTS;
    assign ram_we = acc && (i_req.cmd == CMD_POINT) && idx_ok;
    assign rd_x   = ram_rdata[2*COORD_W-1:COORD_W];
    assign rd_y   = ram_rdata[COORD_W-1:0];

    ppc_ram #(.WIDTH(2 * COORD_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_req.point_index[AW-1:0]),
        .i_wdata ({i_req.coord_x, i_req.coord_y}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    ppc_sqrt #(.W(SQ_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    ppc_div #(.W(PROD_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_quot     (div_q)
    );

    ppc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (r_pose_hd),
        .o_busy  (cor_busy),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    // shared multiplier
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            ST_M0:   begin m_a = MUL_W'(r_ex); m_b = MUL_W'(r_ex); end
            ST_M1:   begin m_a = MUL_W'(r_ey); m_b = MUL_W'(r_ey); end
            ST_M2:   begin m_a = MUL_W'(r_fx); m_b = MUL_W'(r_ey); end
            ST_M3:   begin m_a = MUL_W'(r_fy); m_b = MUL_W'(r_ex); end
            ST_M4:   begin m_a = MUL_W'(r_fx); m_b = MUL_W'(r_ex); end
            ST_M5:   begin m_a = MUL_W'(r_fy); m_b = MUL_W'(r_ey); end
            ST_R0:   begin m_a = signed'({3'b000, r_look}); m_b = signed'({3'b000, r_look}); end
            ST_R1:   begin m_a = signed'({3'b000, r_d}); m_b = signed'({3'b000, r_d}); end
            ST_H0:   begin m_a = MUL_W'(r_ex); m_b = signed'({1'b0, r_u}); end
            ST_H1:   begin m_a = MUL_W'(r_ey); m_b = signed'({1'b0, r_u}); end
            ST_C1:   begin m_a = MUL_W'(r_dx); m_b = MUL_W'(r_dx); end
            ST_C2:   begin m_a = MUL_W'(r_dy); m_b = MUL_W'(r_dy); end
            ST_C5:   begin m_a = MUL_W'(r_dx); m_b = MUL_W'(cor_cos); end
            ST_C6:   begin m_a = MUL_W'(r_dy); m_b = MUL_W'(cor_sin); end
            ST_C7:   begin m_a = MUL_W'(r_dy); m_b = MUL_W'(cor_cos); end
            ST_C8:   begin m_a = MUL_W'(r_dx); m_b = MUL_W'(cor_sin); end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end

    assign m_p = m_a * m_b;

    // root selection, hit point and curvature arithmetic
    always_comb begin
        n_ext  = signed'({{(PROD_W-ROOT_W){1'b0}}, r_n});
        h_ext  = signed'({{(PROD_W-ROOT_W){1'b0}}, sq_root});
        s_val  = r_dot[PROD_W-1] ? signed'(div_q) : -signed'(div_q);
        u_lo   = s_val - h_ext;
        u_hi   = s_val + h_ext;
        lo_ok  = !u_lo[PROD_W-1] && (u_lo <= n_ext);
        hi_ok  = !u_hi[PROD_W-1] && (u_hi <= n_ext);
        h_sign = (r_state == ST_H3) ? r_t0[PROD_W-1] : r_t1[PROD_W-1];
        h_base = (r_state == ST_H3) ? r_sx : r_sy;
        h_off  = h_sign ? -signed'({1'b0, div_q[ROOT_W-1:0]})
                        : signed'({1'b0, div_q[ROOT_W-1:0]});
        h_sum  = MUL_W'(h_base) + h_off;
        ss_val = r_t0 + r_prod;
        neg_q  = (div_q > PROD_W'(33'h1_0000_0000 >> 1)) ? 33'h0_8000_0000 : div_q[32:0];
        if (r_pos) begin
            curv = (div_q > PROD_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : div_q[CURV_W-1:0];
        end else begin
            curv = 32'(33'd0 - neg_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_a     = '0;
        div_b     = '0;
        sq_start  = 1'b0;
        sq_rad    = '0;
        cor_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (acc && i_req.cmd == CMD_TICK) begin
                    if (r_path_ok && r_pose_ok && r_path_len >= 9'd2) begin
                        n_state = ST_RD;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_RD: n_state = ST_LD;
            ST_LD: n_state = r_first ? ST_RD : ST_M0;
            ST_M0: n_state = ST_M1;
            ST_M1: n_state = ST_M2;
            ST_M2: n_state = ST_M3;
            ST_M3: n_state = ST_M4;
            ST_M4: n_state = ST_M5;
            ST_M5: n_state = ST_M6;
            ST_M6: begin
                if (r_a == '0) begin
                    n_state = ST_NEXT;
                end else begin
                    sq_start = 1'b1;
                    sq_rad   = r_a[SQ_W-1:0];
                    n_state  = ST_SQN;
                end
            end
            ST_SQN: begin
                if (!sq_busy) begin
                    div_start = 1'b1;
                    div_a     = mag_of(r_cross);
                    div_b     = PROD_W'(sq_root);
                    n_state   = ST_DVD;
                end
            end
            ST_DVD: begin
                if (!div_busy) begin
                    n_state = (div_q > PROD_W'(r_look)) ? ST_NEXT : ST_R0;
                end
            end
            ST_R0: n_state = ST_R1;
            ST_R1: n_state = ST_R2;
            ST_R2: begin
                sq_start  = 1'b1;
                sq_rad    = SQ_W'(r_t0 - r_prod);
                div_start = 1'b1;
                div_a     = mag_of(r_dot);
                div_b     = PROD_W'(r_n);
                n_state   = ST_WHS;
            end
            ST_WHS: begin
                if (!sq_busy && !div_busy) begin
                    n_state = (lo_ok || hi_ok) ? ST_H0 : ST_NEXT;
                end
            end
            ST_H0: n_state = ST_H1;
            ST_H1: begin
                div_start = 1'b1;
                div_a     = mag_of(r_prod);
                div_b     = PROD_W'(r_n);
                n_state   = ST_H2;
            end
            ST_H2: n_state = ST_H3;
            ST_H3: begin
                if (!div_busy) begin
                    div_start = 1'b1;
                    div_a     = mag_of(r_t1);
                    div_b     = PROD_W'(r_n);
                    n_state   = ST_H4;
                end
            end
            ST_H4: begin
                if (!div_busy) begin
                    n_state = ST_C0;
                end
            end
            ST_C0: begin
                cor_start = 1'b1;
                n_state   = ST_C1;
            end
            ST_C1: n_state = ST_C2;
            ST_C2: n_state = ST_C3;
            ST_C3: n_state = ST_C4;
            ST_C4: begin
                if (r_r2 == '0) begin
                    n_state = ST_OUT;
                end else if (!cor_busy) begin
                    n_state = ST_C5;
                end
            end
            ST_C5: n_state = ST_C6;
            ST_C6: n_state = ST_C7;
            ST_C7: n_state = ST_C8;
            ST_C8: n_state = ST_C9;
            ST_C9: begin
                div_start = 1'b1;
                div_a     = mag_of(r_cross) << CURV_SHIFT;
                div_b     = r_r2;
                n_state   = ST_C10;
            end
            ST_C10: begin
                if (!div_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_NEXT: begin
                n_state = ({1'b0, r_idx} + 10'd1 >= {1'b0, r_path_len}) ? ST_OUT : ST_RD;
            end
            ST_OUT: begin
                if (!r_rsp_valid || !i_rsp_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len  <= '0;
            r_path_ok   <= 1'b0;
            r_pose_ok   <= 1'b0;
            r_pose_x    <= '0;
            r_pose_y    <= '0;
            r_pose_hd   <= '0;
            r_look      <= LOOK_RESET;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_look <= i_cfg_data;
            end
            if (ram_we && i_req.last_point) begin
                r_path_len <= {1'b0, i_req.point_index} + 9'd1;
                r_path_ok  <= 1'b1;
            end
            if (acc && i_req.cmd == CMD_POSE) begin
                r_pose_x  <= i_req.coord_x;
                r_pose_y  <= i_req.coord_y;
                r_pose_hd <= i_req.heading;
                r_pose_ok <= 1'b1;
            end
            if (r_state == ST_OUT && (!r_rsp_valid || !i_rsp_stall)) begin
                r_rsp_valid <= 1'b1;
            end else if (r_rsp_valid && !i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= m_p;
        case (r_state)
            ST_IDLE: begin
                r_idx   <= '0;
                r_first <= 1'b1;
                r_res   <= '0;
            end
            ST_LD: begin
                if (r_first) begin
                    r_sx    <= rd_x;
                    r_sy    <= rd_y;
                    r_first <= 1'b0;
                    r_idx   <= 9'd1;
                end else begin
                    r_x1 <= rd_x;
                    r_y1 <= rd_y;
                    r_ex <= DIFF_W'(rd_x) - DIFF_W'(r_sx);
                    r_ey <= DIFF_W'(rd_y) - DIFF_W'(r_sy);
                    r_fx <= DIFF_W'(r_sx) - DIFF_W'(r_pose_x);
                    r_fy <= DIFF_W'(r_sy) - DIFF_W'(r_pose_y);
                end
            end
            ST_M1:  r_t0 <= r_prod;
            ST_M2:  r_a <= r_t0 + r_prod;
            ST_M3:  r_t0 <= r_prod;
            ST_M4:  r_cross <= r_t0 - r_prod;
            ST_M5:  r_t0 <= r_prod;
            ST_M6:  r_dot <= r_t0 + r_prod;
            ST_SQN: r_n <= sq_root;
            ST_DVD: r_d <= div_q[LOOK_W-1:0];
            ST_R1:  r_t0 <= r_prod;
            ST_WHS: r_u <= lo_ok ? u_lo[ROOT_W-1:0] : u_hi[ROOT_W-1:0];
            ST_H1:  r_t0 <= r_prod;
            ST_H2:  r_t1 <= r_prod;
            ST_H3: begin
                if (!div_busy) begin
                    r_hx <= h_sum[COORD_W-1:0];
                end
            end
            ST_H4: begin
                if (!div_busy) begin
                    r_hy <= h_sum[COORD_W-1:0];
                end
            end
            ST_C0: begin
                r_dx <= DIFF_W'(r_hx) - DIFF_W'(r_pose_x);
                r_dy <= DIFF_W'(r_hy) - DIFF_W'(r_pose_y);
                r_res.curvature    <= '0;
                r_res.velocity_on  <= 1'b1;
                r_res.target_found <= 1'b1;
            end
            ST_C2:  r_t0 <= r_prod;
            ST_C3:  r_r2 <= PROD_W'(r_t0 + r_prod);
            ST_C6:  r_t0 <= r_prod;
            ST_C7:  r_cross <= r_t0 - r_prod;
            ST_C8:  r_t0 <= r_prod;
            ST_C9:  r_pos <= ss_val > 0;
            ST_C10: begin
                if (!div_busy) begin
                    r_res.curvature <= curv;
                end
            end
            ST_NEXT: begin
                r_sx  <= r_x1;
                r_sy  <= r_y1;
                r_idx <= r_idx + 9'd1;
            end
            ST_OUT: begin
                if (!r_rsp_valid || !i_rsp_stall) begin
                    r_rsp <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_req_stall = r_state != ST_IDLE;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy) else $error("divider restarted while busy");

    a_sqrt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_busy) else $error("square root restarted while busy");

    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!div_busy && !sq_busy))
        else $error("arithmetic unit busy while idle");

    a_rsp_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && (!o_rsp_valid || !i_rsp_stall)) |=> o_rsp_valid)
        else $error("finished tick not presented");

    a_rsp_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.velocity_on == o_rsp.target_found))
        else $error("velocity and target flags disagree");

endmodule

>>> src/ppc_ram.sv
module ppc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/ppc_sqrt.sv
module ppc_sqrt import ppc_pkg::*; #(
    parameter int W = 50
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_rad,
    output logic           o_busy,
    output logic [W/2-1:0] o_root
);

    localparam int HW = W / 2;
    localparam int RW = HW + 2;
    localparam int CW = $clog2(HW + 1);

    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rad;
    logic [RW-1:0] r_rem;
    logic [HW-1:0] r_root;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
        rem_sh = {r_rem[RW-3:0], r_rad[W-1:W-2]};
        trial  = {r_root, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(HW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_rad  <= {r_rad[W-3:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[HW-2:0], ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_root = r_root;

endmodule

>>> src/ppc_div.sv
module ppc_div import ppc_pkg::*; #(
    parameter int W = 52
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic [W-1:0] o_quot
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [W:0]    rem_sh;
    logic [W+1:0]  trial;
    logic          ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_den};
        ge     = !trial[W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? trial[W-1:0] : rem_sh[W-1:0];
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quo;

endmodule

>>> src/ppc_cordic.sv
module ppc_cordic import ppc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [HEAD_W-1:0]  i_angle,
    output logic                      o_busy,
    output logic signed [TRIG_W-1:0]  o_cos,
    output logic signed [TRIG_W-1:0]  o_sin
);

    logic                    r_busy;
    logic [3:0]              r_step;
    logic                    r_neg;
    logic signed [ANG_W-1:0] r_x;
    logic signed [ANG_W-1:0] r_y;
    logic signed [ANG_W-1:0] r_z;
    logic signed [ANG_W-1:0] z0;
    logic signed [ANG_W-1:0] tx;
    logic signed [ANG_W-1:0] ty;
    logic signed [ANG_W-1:0] xr;
    logic signed [ANG_W-1:0] yr;
    logic signed [TRIG_W-1:0] c_raw;
    logic signed [TRIG_W-1:0] s_raw;

    always_comb begin
        z0    = ANG_W'(i_angle) <<< 17;
        tx    = r_y >>> r_step;
        ty    = r_x >>> r_step;
        xr    = (r_x + 34'sd32768) >>> 16;
        yr    = (r_y + 34'sd32768) >>> 16;
        c_raw = xr[TRIG_W-1:0];
        s_raw = yr[TRIG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_step == 4'(CORDIC_N - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_x    <= GAIN_Q30;
            r_y    <= '0;
            if (z0 > HALF_PI_Q30) begin
                r_z   <= z0 - PI_Q30;
                r_neg <= 1'b1;
            end else if (z0 < -HALF_PI_Q30) begin
                r_z   <= z0 + PI_Q30;
                r_neg <= 1'b1;
            end else begin
                r_z   <= z0;
                r_neg <= 1'b0;
            end
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_z >= 0) begin
                r_x <= r_x - tx;
                r_y <= r_y + ty;
                r_z <= r_z - atan_q30(r_step);
            end else begin
                r_x <= r_x + tx;
                r_y <= r_y - ty;
                r_z <= r_z + atan_q30(r_step);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_cos  = r_neg ? -c_raw : c_raw;
    assign o_sin  = r_neg ? -s_raw : s_raw;

endmodule
